>>> rtl/dhcpp_pkg.sv
// shared types, codes and constants of the dhcp option parser
package dhcpp_pkg;

  // option codes with special handling
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_TYPE   = 8'd53;
  localparam logic [7:0] OPT_REQ    = 8'd55;
  localparam logic [7:0] OPT_VENDOR = 8'd60;
  localparam logic [7:0] OPT_END    = 8'd255;

  // default count limit and record queue depth
  localparam int MAX_OPTS_DEF = 32;
  localparam int Q_DEPTH_DEF  = 4;

  // record kinds
  typedef enum logic [1:0] {
    REC_OPTION  = 2'd0,
    REC_REQUEST = 2'd1,
    REC_VENDOR  = 2'd2,
    REC_SUMMARY = 2'd3
  } rec_kind_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  // result item
  typedef struct packed {
    rec_kind_t  rec_kind;
    logic [7:0] value;
    logic [7:0] position;
    logic [7:0] msg_type;
    logic [5:0] opt_count;
    logic [5:0] req_count;
    logic [7:0] vendor_len;
    logic       truncated;
    logic       overflow;
    logic       last_out;
  } out_item_t;

  // records pushed by the parser in one cycle, first present in rec0
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  rec0;
    out_item_t  rec1;
  } push_t;

  // queue status seen by the parser and the output stage
  typedef struct packed {
    logic space_ok;
    logic head_valid;
  } q_stat_t;

endpackage

>>> rtl/dhcpp_front.sv
// option walker: accepts bytes, tracks tlv state and builds records
module dhcpp_front #(
  parameter int MAX_OPTS = dhcpp_pkg::MAX_OPTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dhcpp_pkg::in_item_t in_data,
  input  dhcpp_pkg::q_stat_t  q_stat,
  output dhcpp_pkg::push_t    push
);
  import dhcpp_pkg::*;

  localparam logic [5:0] MAX_C = 6'(MAX_OPTS);

  phase_t     phase_r, phase_nxt, phase_step;
  logic [7:0] code_r, code_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] left_r, left_nxt;
  logic [5:0] opt_tot_r, opt_tot_nxt;
  logic [5:0] req_tot_r, req_tot_nxt;
  logic [7:0] mtype_r, mtype_nxt;
  logic [7:0] vlen_r, vlen_nxt;
  logic       ovf_r, ovf_nxt;

  logic       in_fire;
  logic [7:0] left_dec;
  logic       rec_en;
  rec_kind_t  rec_kind;
  logic [7:0] rec_pos;
  out_item_t  rec_a, rec_sum;

  assign in_stall = !q_stat.space_ok;
  assign in_fire  = in_valid && !q_stat.space_ok == 1'b0;
  assign left_dec = left_r - 8'd1;

  // next phase
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      PH_CODE: begin
        if (in_data.data_byte == OPT_END) begin
          phase_step = PH_DONE;
        end else if (in_data.data_byte != OPT_PAD) begin
          phase_step = PH_LEN;
        end
      end
      PH_LEN: begin
        phase_step = (in_data.data_byte == 8'd0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        if (left_dec == 8'd0) begin
          phase_step = PH_CODE;
        end
      end
      PH_DONE: phase_step = PH_DONE;
      default: phase_step = PH_CODE;
    endcase
    phase_nxt = in_data.last ? PH_CODE : phase_step;
  end

  // datapath state and record contents
  always_comb begin
    code_nxt    = code_r;
    len_nxt     = len_r;
    left_nxt    = left_r;
    opt_tot_nxt = opt_tot_r;
    req_tot_nxt = req_tot_r;
    mtype_nxt   = mtype_r;
    vlen_nxt    = vlen_r;
    ovf_nxt     = ovf_r;
    rec_en      = 1'b0;
    rec_kind    = REC_OPTION;
    rec_pos     = 8'd0;
    unique case (phase_r)
      PH_CODE: begin
        rec_en   = 1'b1;
        rec_kind = REC_OPTION;
        rec_pos  = {2'b00, opt_tot_r};
        code_nxt = in_data.data_byte;
        if (opt_tot_r >= MAX_C) begin
          ovf_nxt = 1'b1;
        end else begin
          opt_tot_nxt = opt_tot_r + 6'd1;
        end
      end
      PH_LEN: begin
        len_nxt  = in_data.data_byte;
        left_nxt = in_data.data_byte;
        if (code_r == OPT_VENDOR) begin
          vlen_nxt = 8'd0;
        end
      end
      PH_DATA: begin
        left_nxt = left_dec;
        if (code_r == OPT_TYPE && len_r == 8'd1) begin
          mtype_nxt = in_data.data_byte;
        end else if (code_r == OPT_REQ) begin
          rec_en   = 1'b1;
          rec_kind = REC_REQUEST;
          rec_pos  = {2'b00, req_tot_r};
          if (req_tot_r >= MAX_C) begin
            ovf_nxt = 1'b1;
          end else begin
            req_tot_nxt = req_tot_r + 6'd1;
          end
        end else if (code_r == OPT_VENDOR) begin
          rec_en   = 1'b1;
          rec_kind = REC_VENDOR;
          rec_pos  = len_r - left_r;
          vlen_nxt = rec_pos + 8'd1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // both records carry the state as updated by this byte
    rec_a.rec_kind   = rec_kind;
    rec_a.value      = in_data.data_byte;
    rec_a.position   = rec_pos;
    rec_a.msg_type   = mtype_nxt;
    rec_a.opt_count  = opt_tot_nxt;
    rec_a.req_count  = req_tot_nxt;
    rec_a.vendor_len = vlen_nxt;
    rec_a.truncated  = 1'b0;
    rec_a.overflow   = ovf_nxt;
    rec_a.last_out   = 1'b0;

    rec_sum            = rec_a;
    rec_sum.rec_kind   = REC_SUMMARY;
    rec_sum.value      = 8'd0;
    rec_sum.position   = 8'd0;
    rec_sum.truncated  = (phase_step == PH_LEN) || (phase_step == PH_DATA);
    rec_sum.last_out   = 1'b1;
  end

  // pack the records for the queue, first present in slot 0
  always_comb begin
    push.rec0 = rec_en ? rec_a : rec_sum;
    push.rec1 = rec_sum;
    push.cnt  = 2'd0;
    if (in_fire) begin
      push.cnt = {1'b0, rec_en} + {1'b0, in_data.last};
    end
  end

  // state registers, cleared at the end of each packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CODE;
      code_r    <= 8'd0;
      len_r     <= 8'd0;
      left_r    <= 8'd0;
      opt_tot_r <= 6'd0;
      req_tot_r <= 6'd0;
      mtype_r   <= 8'd0;
      vlen_r    <= 8'd0;
      ovf_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      if (in_data.last) begin
        code_r    <= 8'd0;
        len_r     <= 8'd0;
        left_r    <= 8'd0;
        opt_tot_r <= 6'd0;
        req_tot_r <= 6'd0;
        mtype_r   <= 8'd0;
        vlen_r    <= 8'd0;
        ovf_r     <= 1'b0;
      end else begin
        code_r    <= code_nxt;
        len_r     <= len_nxt;
        left_r    <= left_nxt;
        opt_tot_r <= opt_tot_nxt;
        req_tot_r <= req_tot_nxt;
        mtype_r   <= mtype_nxt;
        vlen_r    <= vlen_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

endmodule

>>> rtl/dhcpp_queue.sv
// record queue: up to two writes and one read per cycle
module dhcpp_queue #(
  parameter int Q_DEPTH = dhcpp_pkg::Q_DEPTH_DEF,
  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1,
  localparam int CW = $clog2(Q_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhcpp_pkg::push_t     push,
  input  logic                 pop,
  output dhcpp_pkg::q_stat_t   q_stat,
  output dhcpp_pkg::out_item_t head,
  output logic [CW-1:0]        q_count
);
  import dhcpp_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(Q_DEPTH - 1);

  out_item_t     mem_r [Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // wrapping pointer increment
  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    inc_ptr = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr_p1         = inc_ptr(wr_ptr_r);
  assign head              = mem_r[rd_ptr_r];
  assign q_count           = count_r;
  assign q_stat.head_valid = (count_r != '0);
  assign q_stat.space_ok   = (count_r <= CW'(Q_DEPTH - 2));

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = inc_ptr(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.rec1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/dhcpp_back.sv
// output stage: drains the queue into the result register
module dhcpp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhcpp_pkg::q_stat_t   q_stat,
  input  dhcpp_pkg::out_item_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhcpp_pkg::out_item_t out_data
);
  import dhcpp_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // load a new record when the register is empty or being taken
  assign pop           = q_stat.head_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

endmodule

>>> rtl/dhcpp_core.sv
// no logic here: the top level is dhcp_option_tlv_parser_core in its own file

>>> rtl/dhcp_option_tlv_parser_core.sv
// Top level of the DHCP option parser. Bytes of the option area (after the
// magic cookie) enter one per cycle while in_stall is low, the last byte
// flagged. The walker emits an option record per code byte (pad and end
// included), a requested-option record per byte of option 55 and a vendor
// record per byte of option 60, and a summary record after the last byte;
// option 53 of length 1 sets the message type and bytes after END give no
// record. Records pass through a Q_DEPTH-entry queue (four by default) into
// the output register, one record leaves per cycle while out_stall is low,
// so the sustained rate is one byte per cycle while bytes give at most one
// record each; a byte giving two records (a last byte that also yields an
// option, request or vendor record) is absorbed by the queue. The input
// stalls while fewer than two queue entries are free. Counts saturate at
// MAX_OPTS and all packet state clears after the summary.
module dhcp_option_tlv_parser_core #(
  parameter int MAX_OPTS = dhcpp_pkg::MAX_OPTS_DEF,
  parameter int Q_DEPTH  = dhcpp_pkg::Q_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dhcpp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhcpp_pkg::out_item_t out_data
);
  import dhcpp_pkg::*;

  localparam int CW = $clog2(Q_DEPTH + 1);

  push_t         push;
  q_stat_t       q_stat;
  out_item_t     head;
  logic          pop;
  logic [CW-1:0] q_count;

  dhcpp_front #(
    .MAX_OPTS (MAX_OPTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push)
  );

  dhcpp_queue #(
    .Q_DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .q_stat  (q_stat),
    .head    (head),
    .q_count (q_count)
  );

  dhcpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(Q_DEPTH))
    else $error("record queue overfilled");

  // a last byte always leaves a summary on its way out
  a_sum_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> (q_count != '0 || out_valid))
    else $error("summary record missing after last byte");

  // only summary records close a packet
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_out) |-> (out_data.rec_kind == REC_SUMMARY))
    else $error("last_out on a non-summary record");

  // truncation is reported on summaries only
  a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rec_kind != REC_SUMMARY) |->
      (!out_data.truncated && !out_data.last_out))
    else $error("summary flags on a data record");
`endif

endmodule

>>> test/testbench.sv
// self-checking testbench of the dhcp option parser core with a built-in walker model
`timescale 1ns / 100ps

module testbench;
  import dhcpp_pkg::*;

  localparam int COUNT_CAP    = MAX_OPTS_DEF;
  localparam int RANDOM_ITEMS = 1100;

  // pending byte with an optional hold until all records are out
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pend_byte_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pend_byte_t pending_bytes[$];
  out_item_t  expected_recs[$];
  int         mismatch_cnt = 0;
  int         rec_seen = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         in_calm = 0;
  int         out_calm = 0;

  // walker state of the model
  phase_t     walk_phase;
  logic [7:0] walk_code;
  logic [7:0] walk_len;
  logic [7:0] walk_left;
  logic [5:0] seen_opts;
  logic [5:0] seen_reqs;
  logic [7:0] seen_type;
  logic [7:0] seen_vlen;
  logic       seen_ovf;

  dhcp_option_tlv_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 200) begin
      $display("mismatch at %0t ns, record %0d: %s", $time, rec_seen, msg);
    end
    mismatch_cnt++;
  endtask

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_idle(inout int calm_run);
    int r;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_run = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic clear_walk();
    walk_phase = PH_CODE;
    walk_code  = '0;
    walk_len   = '0;
    walk_left  = '0;
    seen_opts  = '0;
    seen_reqs  = '0;
    seen_type  = '0;
    seen_vlen  = '0;
    seen_ovf   = 1'b0;
  endtask

  function automatic out_item_t make_record(rec_kind_t kind, logic [7:0] val,
                                            logic [7:0] pos, logic trunc, logic lastf);
    out_item_t r;
    r.rec_kind   = kind;
    r.value      = val;
    r.position   = pos;
    r.msg_type   = seen_type;
    r.opt_count  = seen_opts;
    r.req_count  = seen_reqs;
    r.vendor_len = seen_vlen;
    r.truncated  = trunc;
    r.overflow   = seen_ovf;
    r.last_out   = lastf;
    return r;
  endfunction

  // saturating count; the record position keeps the count before the bump
  task automatic bump_count(inout logic [5:0] cnt, output logic [7:0] pos);
    pos = {2'b00, cnt};
    if (cnt >= COUNT_CAP) seen_ovf = 1'b1;
    else cnt = cnt + 6'd1;
  endtask

  // walk one byte and queue the records it gives
  task automatic predict_byte(input in_item_t it);
    logic [7:0] b;
    logic [7:0] pos;
    logic       trunc;
    b = it.data_byte;
    case (walk_phase)
      PH_CODE: begin
        bump_count(seen_opts, pos);
        walk_code = b;
        expected_recs.push_back(make_record(REC_OPTION, b, pos, 1'b0, 1'b0));
        if (b == OPT_END) walk_phase = PH_DONE;
        else if (b != OPT_PAD) walk_phase = PH_LEN;
      end
      PH_LEN: begin
        walk_len  = b;
        walk_left = b;
        if (walk_code == OPT_VENDOR) seen_vlen = '0;
        walk_phase = (b == 8'd0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        if (walk_code == OPT_TYPE && walk_len == 8'd1) begin
          seen_type = b;
        end else if (walk_code == OPT_REQ) begin
          bump_count(seen_reqs, pos);
          expected_recs.push_back(make_record(REC_REQUEST, b, pos, 1'b0, 1'b0));
        end else if (walk_code == OPT_VENDOR) begin
          pos = walk_len - walk_left;
          seen_vlen = pos + 8'd1;
          expected_recs.push_back(make_record(REC_VENDOR, b, pos, 1'b0, 1'b0));
        end
        walk_left = walk_left - 8'd1;
        if (walk_left == 8'd0) walk_phase = PH_CODE;
      end
      default: ;
    endcase
    // summary closes the packet and clears all packet state
    if (it.last) begin
      trunc = (walk_phase == PH_LEN || walk_phase == PH_DATA);
      expected_recs.push_back(make_record(REC_SUMMARY, 8'd0, 8'd0, trunc, 1'b1));
      clear_walk();
    end
  endtask

  task automatic check_record(input out_item_t got);
    out_item_t want;
    if (expected_recs.size() == 0) begin
      report_mismatch($sformatf("record with none expected: %h", got));
      rec_seen++;
      return;
    end
    want = expected_recs.pop_front();
    if (got.rec_kind !== want.rec_kind)
      report_mismatch($sformatf("rec_kind %0d, want %0d", got.rec_kind, want.rec_kind));
    if (got.value !== want.value)
      report_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
    if (got.position !== want.position)
      report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
    if (got.msg_type !== want.msg_type)
      report_mismatch($sformatf("msg_type %0d, want %0d", got.msg_type, want.msg_type));
    if (got.opt_count !== want.opt_count)
      report_mismatch($sformatf("opt_count %0d, want %0d", got.opt_count, want.opt_count));
    if (got.req_count !== want.req_count)
      report_mismatch($sformatf("req_count %0d, want %0d", got.req_count, want.req_count));
    if (got.vendor_len !== want.vendor_len)
      report_mismatch($sformatf("vendor_len %0d, want %0d", got.vendor_len, want.vendor_len));
    if (got.truncated !== want.truncated)
      report_mismatch($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
    rec_seen++;
  endtask

  // queue one packet, last flag on its final byte
  task automatic send_packet(input logic [7:0] pkt[$], input bit drain);
    pend_byte_t p;
    foreach (pkt[i]) begin
      p.item.data_byte = pkt[i];
      p.item.last      = (i == pkt.size() - 1);
      p.drain_first    = drain && (i == 0);
      pending_bytes.push_back(p);
    end
  endtask

  task automatic add_random_packet(input bit drain);
    logic [7:0] pkt[$];
    logic [7:0] code;
    int         kind;
    int         len;
    int         keep;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise
      repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 18) begin
      // enough codes or requests to bring the counts near or into saturation
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(30, 40)) pkt.push_back(OPT_PAD);
      end else begin
        len = $urandom_range(30, 45);
        pkt.push_back(OPT_REQ);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
      end
      pkt.push_back(OPT_END);
    end else begin
      // well-formed option list with random content
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 5))
          0:       code = OPT_PAD;
          1:       code = OPT_TYPE;
          2:       code = OPT_REQ;
          3:       code = OPT_VENDOR;
          default: code = 8'($urandom_range(1, 254));
        endcase
        pkt.push_back(code);
        if (code != OPT_PAD) begin
          if (code == OPT_TYPE && $urandom_range(0, 3) != 0) len = 1;
          else if ($urandom_range(0, 19) == 0) len = $urandom_range(7, 20);
          else len = $urandom_range(0, 6);
          pkt.push_back(8'(len));
          repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) < 8) begin
        pkt.push_back(OPT_END);
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
      end
    end
    // broken packets: cut short anywhere
    if (kind >= 12 && pkt.size() > 1 && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    if (pkt.size() == 0) pkt.push_back(8'($urandom_range(0, 255)));
    send_packet(pkt, drain);
  endtask

  // driver
  always @(posedge clk) begin
    pend_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      clear_walk();
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain_first && expected_recs.size() > 0)) begin
          nxt = pending_bytes.pop_front();
          in_data  <= nxt.item;
          in_valid <= 1'b1;
          gap_left = pick_idle(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_record(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(out_calm);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [7:0] pkt[$];
    int         pkt_no;
    // every special code, both byte extremes, vendor restart, bytes after end
    pkt = '{OPT_PAD, OPT_TYPE, 8'd1, 8'hFF, OPT_REQ, 8'd1, 8'h00,
            OPT_VENDOR, 8'd2, 8'h80, 8'h7F, OPT_VENDOR, 8'd0, OPT_END, 8'h11};
    send_packet(pkt, 1'b0);
    // type option of another length, then end right after a code
    pkt = '{OPT_TYPE, 8'd2, 8'd7, 8'd9, 8'd1};
    send_packet(pkt, 1'b0);
    // end inside the data of an option
    pkt = '{8'd3, 8'd4, 8'd1};
    send_packet(pkt, 1'b0);
    // zero length option closing the packet without end
    pkt = '{8'd12, 8'd0};
    send_packet(pkt, 1'b0);
    // end code on the last byte gives two records
    pkt = '{OPT_END};
    send_packet(pkt, 1'b0);
    pkt_no = 0;
    while (pending_bytes.size() < RANDOM_ITEMS + 26) begin
      add_random_packet(pkt_no % 15 == 0);
      pkt_no++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_recs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/dhcpp_pkg.sv
rtl/dhcpp_front.sv
rtl/dhcpp_queue.sv
rtl/dhcpp_back.sv
rtl/dhcpp_core.sv
rtl/dhcp_option_tlv_parser_core.sv
test/testbench.sv
